// ----- design/tle_pkg.sv -----
// Shared types and constants for the terminal line editor.
package tle_pkg;

    localparam int LINE_CAPACITY_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
    localparam logic [7:0] CH_THREE = 8'h33; // '3'
    localparam logic [7:0] CH_TILDE = 8'h7E; // '~'
    localparam logic [7:0] CH_UP    = 8'h41; // 'A'
    localparam logic [7:0] CH_DOWN  = 8'h42; // 'B'
    localparam logic [7:0] CH_RIGHT = 8'h43; // 'C'
    localparam logic [7:0] CH_LEFT  = 8'h44; // 'D'

    typedef enum logic [2:0] {
        KIND_ECHO   = 3'd0,
        KIND_LEFT   = 3'd1,
        KIND_RIGHT  = 3'd2,
        KIND_LINE   = 3'd3,
        KIND_PROMPT = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_BACKSPACE,
        CMD_DELETE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_RECALL,
        CMD_CLEAR,
        CMD_RETURN
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } cmd_entry_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } tok_t;

endpackage

// ----- design/terminal_line_editor.sv -----
// Top level of the terminal line editor: decoder, command queue, executor.
//
//  channel   | dir | handshake         | payload
//  s_ (rx)   | in  | s_tvalid/s_tready | s_tdata[7:0] rx_byte
//  m_ (echo) | out | m_tvalid/m_tready | m_tdata token_byte, m_tuser token_kind,
//            |     |                   | m_tlast last_token
//
// The decoder takes one byte per cycle while the command queue has room.
// The executor starts a command from the queue head, emits its tokens one per
// cycle while the m_ side accepts them, and then closes the command.
// A stalled m_ side holds the executor; the queue lets bytes keep arriving.
// Reset (aresetn low, synchronous) clears the line store, cursor and queue.
module terminal_line_editor #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF,
    parameter int QUEUE_DEPTH   = tle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_byte
    output logic [2:0] m_tuser,   // [2:0] token_kind
    output logic       m_tlast
);

    logic                q_full, q_push, q_pop, q_valid;
    tle_pkg::cmd_entry_t q_entry, q_head;

    tle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    tle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    tle_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- design/tle_front.sv -----
// Escape decoder: turns received bytes into editing commands.
module tle_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    input  logic                q_full,
    output logic                q_push,
    output tle_pkg::cmd_entry_t q_entry
);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_ESC,
        PH_CSI,
        PH_CSI3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       hit;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && hit;

    always_comb begin
        phase_next    = phase_reg;
        hit           = 1'b0;
        q_entry.cmd   = tle_pkg::CMD_INSERT;
        q_entry.data  = s_tdata;
        case (phase_reg)
            PH_ESC: begin
                phase_next = (s_tdata == tle_pkg::CH_LBRK) ? PH_CSI : PH_NORMAL;
            end
            PH_CSI: begin
                phase_next = (s_tdata == tle_pkg::CH_THREE) ? PH_CSI3 : PH_NORMAL;
                if (s_tdata == tle_pkg::CH_LEFT) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_LEFT;
                end else if (s_tdata == tle_pkg::CH_RIGHT) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_RIGHT;
                end else if (s_tdata == tle_pkg::CH_UP) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_RECALL;
                end else if (s_tdata == tle_pkg::CH_DOWN) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_CLEAR;
                end
            end
            PH_CSI3: begin
                phase_next = PH_NORMAL;
                if (s_tdata == tle_pkg::CH_TILDE) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_DELETE;
                end
            end
            default: begin
                if (s_tdata == tle_pkg::CH_ESC) begin
                    phase_next = PH_ESC;
                end else if (s_tdata == tle_pkg::CH_NUL) begin
                    hit = 1'b0;
                end else if (s_tdata == tle_pkg::CH_DEL || s_tdata == tle_pkg::CH_BS) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_BACKSPACE;
                end else if (s_tdata == tle_pkg::CH_CR) begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_RETURN;
                end else begin
                    hit = 1'b1; q_entry.cmd = tle_pkg::CMD_INSERT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- design/tle_queue.sv -----
// Small command queue between decoder and executor.
module tle_queue #(
    parameter int DEPTH = tle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tle_pkg::cmd_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tle_pkg::cmd_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tle_pkg::cmd_entry_t mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ----- design/tle_back.sv -----
// Executor: edits the line store and emits echo tokens one per cycle while the m_ side is not stalled.
module tle_back #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  tle_pkg::cmd_entry_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int IW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] CAP_W = CW'(LINE_CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BSLEFT,
        ST_CR,
        ST_LF,
        ST_RUN,
        ST_SPACE,
        ST_LEFTS,
        ST_RIGHTS,
        ST_TRIP,
        ST_PROMPT,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    tle_pkg::cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]   cur_reg, cur_next, len_reg, len_next;
    logic            fresh_reg, fresh_next;
    logic [7:0]      store_reg [LINE_CAPACITY];
    logic [7:0]      store_next [LINE_CAPACITY];
    logic [CW-1:0]   idx_reg, idx_next, end_reg, end_next;
    logic [CW-1:0]   cnt_reg, cnt_next, tcnt_reg, tcnt_next;
    logic [1:0]      sub_reg, sub_next;
    logic            hold_v_reg, hold_v_next;
    tle_pkg::tok_t   hold_reg, hold_next;
    logic            out_v_reg, out_v_next, out_last_reg, out_last_next;
    tle_pkg::tok_t   out_reg, out_next;

    logic            adv, gen;
    tle_pkg::tok_t   gen_tok;
    logic [CW-1:0]   base_len, nl, d;
    logic [7:0]      base [LINE_CAPACITY];

    assign adv      = !out_v_reg || m_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign q_pop    = adv && (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        len_next   = len_reg;
        fresh_next = fresh_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        cnt_next   = cnt_reg;
        tcnt_next  = tcnt_reg;
        sub_next   = sub_reg;
        for (int i = 0; i < LINE_CAPACITY; i++) begin
            store_next[i] = store_reg[i];
            base[i]       = fresh_reg ? 8'h00 : store_reg[i];
        end
        base_len     = fresh_reg ? cur_reg : len_reg;
        nl           = (base_len < CAP_W) ? base_len + 1'b1 : CAP_W;
        d            = (q_head.cmd == tle_pkg::CMD_BACKSPACE) ? cur_reg - 1'b1 : cur_reg;
        gen          = 1'b0;
        gen_tok.kind = tle_pkg::KIND_ECHO;
        gen_tok.data = 8'h00;

        if (adv) begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_next   = q_head.cmd;
                        state_next = ST_DONE;
                        case (q_head.cmd)
                            tle_pkg::CMD_INSERT: begin
                                fresh_next = 1'b0;
                                for (int i = 0; i < LINE_CAPACITY; i++) begin
                                    store_next[i] = base[i];
                                end
                                len_next = base_len;
                                if (cur_reg < CAP_W) begin
                                    for (int i = 0; i < LINE_CAPACITY; i++) begin
                                        if (CW'(i) == cur_reg) begin
                                            store_next[i] = q_head.data;
                                        end else if (CW'(i) > cur_reg && CW'(i) < nl) begin
                                            store_next[i] = base[IW'(i - 1)];
                                        end
                                    end
                                    len_next   = nl;
                                    idx_next   = cur_reg;
                                    end_next   = nl;
                                    cnt_next   = nl - cur_reg - 1'b1;
                                    cur_next   = cur_reg + 1'b1;
                                    state_next = ST_RUN;
                                end
                            end
                            tle_pkg::CMD_BACKSPACE, tle_pkg::CMD_DELETE: begin
                                if ((q_head.cmd == tle_pkg::CMD_BACKSPACE && cur_reg != '0) ||
                                    (q_head.cmd == tle_pkg::CMD_DELETE && cur_reg < len_reg)) begin
                                    for (int i = 0; i < LINE_CAPACITY; i++) begin
                                        if (CW'(i) >= d && CW'(i + 1) < len_reg) begin
                                            store_next[i] = store_reg[IW'(i + 1)];
                                        end else if (CW'(i + 1) == len_reg) begin
                                            store_next[i] = 8'h00;
                                        end
                                    end
                                    cur_next   = d;
                                    len_next   = len_reg - 1'b1;
                                    idx_next   = d;
                                    end_next   = len_reg - 1'b1;
                                    cnt_next   = len_reg - d;
                                    state_next = (q_head.cmd == tle_pkg::CMD_BACKSPACE) ?
                                                 ST_BSLEFT : ST_RUN;
                                end
                            end
                            tle_pkg::CMD_LEFT: begin
                                cnt_next   = (cur_reg != '0) ? CW'(1) : '0;
                                cur_next   = (cur_reg != '0) ? cur_reg - 1'b1 : cur_reg;
                                state_next = ST_LEFTS;
                            end
                            tle_pkg::CMD_RIGHT: begin
                                cnt_next   = (cur_reg < len_reg) ? CW'(1) : '0;
                                cur_next   = (cur_reg < len_reg) ? cur_reg + 1'b1 : cur_reg;
                                tcnt_next  = '0;
                                state_next = ST_RIGHTS;
                            end
                            tle_pkg::CMD_RECALL: begin
                                fresh_next = 1'b0;
                                if (cur_reg == '0 && len_reg != '0) begin
                                    idx_next   = '0;
                                    end_next   = len_reg;
                                    cur_next   = len_reg;
                                    state_next = ST_RUN;
                                end
                            end
                            tle_pkg::CMD_CLEAR: begin
                                cnt_next   = len_reg - cur_reg;
                                tcnt_next  = len_reg;
                                sub_next   = 2'd0;
                                cur_next   = '0;
                                fresh_next = 1'b1;
                                state_next = ST_RIGHTS;
                            end
                            tle_pkg::CMD_RETURN: begin
                                idx_next   = '0;
                                end_next   = (cur_reg != '0) ? len_reg : '0;
                                cur_next   = '0;
                                fresh_next = 1'b1;
                                state_next = ST_CR;
                            end
                            default: state_next = ST_DONE;
                        endcase
                    end
                end
                ST_BSLEFT: begin
                    gen = 1'b1; gen_tok.kind = tle_pkg::KIND_LEFT;
                    state_next = ST_RUN;
                end
                ST_CR: begin
                    gen = 1'b1; gen_tok.data = tle_pkg::CH_CR;
                    state_next = ST_LF;
                end
                ST_LF: begin
                    gen = 1'b1; gen_tok.data = tle_pkg::CH_LF;
                    state_next = ST_RUN;
                end
                ST_RUN: begin
                    if (idx_reg < end_reg) begin
                        gen          = 1'b1;
                        gen_tok.kind = (cmd_reg == tle_pkg::CMD_RETURN) ?
                                       tle_pkg::KIND_LINE : tle_pkg::KIND_ECHO;
                        gen_tok.data = store_reg[idx_reg[IW-1:0]];
                        idx_next     = idx_reg + 1'b1;
                    end else begin
                        case (cmd_reg)
                            tle_pkg::CMD_INSERT:    state_next = ST_LEFTS;
                            tle_pkg::CMD_BACKSPACE: state_next = ST_SPACE;
                            tle_pkg::CMD_DELETE:    state_next = ST_SPACE;
                            tle_pkg::CMD_RETURN:    state_next = ST_PROMPT;
                            default:                state_next = ST_DONE;
                        endcase
                    end
                end
                ST_SPACE: begin
                    gen = 1'b1; gen_tok.data = tle_pkg::CH_SPACE;
                    state_next = ST_LEFTS;
                end
                ST_LEFTS: begin
                    if (cnt_reg != '0) begin
                        gen = 1'b1; gen_tok.kind = tle_pkg::KIND_LEFT;
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
                ST_RIGHTS: begin
                    if (cnt_reg != '0) begin
                        gen = 1'b1; gen_tok.kind = tle_pkg::KIND_RIGHT;
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        state_next = ST_TRIP;
                    end
                end
                ST_TRIP: begin
                    // left, space, left for every cell of the old line
                    if (tcnt_reg != '0) begin
                        gen = 1'b1;
                        gen_tok.kind = (sub_reg == 2'd1) ? tle_pkg::KIND_ECHO :
                                                           tle_pkg::KIND_LEFT;
                        gen_tok.data = (sub_reg == 2'd1) ? tle_pkg::CH_SPACE : 8'h00;
                        if (sub_reg == 2'd2) begin
                            sub_next  = 2'd0;
                            tcnt_next = tcnt_reg - 1'b1;
                        end else begin
                            sub_next = sub_reg + 1'b1;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
                ST_PROMPT: begin
                    gen = 1'b1; gen_tok.kind = tle_pkg::KIND_PROMPT;
                    state_next = ST_DONE;
                end
                ST_DONE: state_next = ST_IDLE;
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // One token is held back so the final one of a command can carry tlast.
    always_comb begin
        hold_v_next   = hold_v_reg;
        hold_next     = hold_reg;
        out_v_next    = out_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        if (adv) begin
            out_v_next = 1'b0;
            if (gen) begin
                if (hold_v_reg) begin
                    out_v_next    = 1'b1;
                    out_next      = hold_reg;
                    out_last_next = 1'b0;
                end
                hold_next   = gen_tok;
                hold_v_next = 1'b1;
            end else if (state_reg == ST_DONE && hold_v_reg) begin
                out_v_next    = 1'b1;
                out_next      = hold_reg;
                out_last_next = 1'b1;
                hold_v_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= tle_pkg::CMD_INSERT;
            cur_reg    <= '0;
            len_reg    <= '0;
            fresh_reg  <= 1'b1;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            for (int i = 0; i < LINE_CAPACITY; i++) begin
                store_reg[i] <= 8'h00;
            end
        end else begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            cur_reg    <= cur_next;
            len_reg    <= len_next;
            fresh_reg  <= fresh_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
            for (int i = 0; i < LINE_CAPACITY; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        cnt_reg      <= cnt_next;
        tcnt_reg     <= tcnt_next;
        sub_reg      <= sub_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- design/tle_checker.sv -----
// Port-level checks for the terminal line editor, bound to the top level.
module tle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled transfer changed");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tle_pkg::KIND_LEFT || m_tuser == tle_pkg::KIND_RIGHT ||
                     m_tuser == tle_pkg::KIND_PROMPT) |-> m_tdata == 8'h00)
        else $error("nonzero byte on cursor or prompt token");

    a_prompt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tle_pkg::KIND_PROMPT |-> m_tlast)
        else $error("prompt token not last of its byte");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
